// ===== sv/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache.
package salc_pkg;
  localparam int MAX_SETS = 16;
  localparam int MAX_WAYS = 4;
  localparam int ADDR_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int SET_W = $clog2(MAX_SETS);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int LINE_W = $clog2(LINES);
  localparam int SCNT_W = $clog2(MAX_SETS + 1);
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int CNT_W = 32;

  localparam logic [1:0] REG_SET_COUNT = 2'd0;
  localparam logic [1:0] REG_WAY_COUNT = 2'd1;
  localparam logic CMD_PUT = 1'b1;

  // Classified access passed from front to back.
  typedef struct packed {
    logic                 is_put;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic [DATA_BITS-1:0] data;
    logic [WCNT_W-1:0]    ways;
  } req_t;
endpackage

// ===== sv/salc_front.sv =====
// Front end: accepts accesses, splits address into set and tag, queues them.
module salc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [15:0]                 in_address,
  input  logic [31:0]                 in_data_in,
  input  logic [salc_pkg::SCNT_W-1:0] sets,
  input  logic [salc_pkg::WCNT_W-1:0] ways,
  output logic                        q_valid,
  output salc_pkg::req_t              q_req,
  input  logic                        q_pop
);
  import salc_pkg::*;

  logic                 div_act_r, div_act_nxt;
  logic [ADDR_BITS-1:0] rem_r, rem_nxt;
  logic [ADDR_BITS-1:0] quo_r, quo_nxt;
  logic [ADDR_BITS-1:0] rem_sh;
  logic [ADDR_BITS:0]   diff;
  logic [$clog2(ADDR_BITS+1)-1:0] cnt_r, cnt_nxt;
  logic                 put_r;
  logic [DATA_BITS-1:0] data_r;
  logic [SCNT_W-1:0]    sets_r;
  logic [WCNT_W-1:0]    ways_r;
  req_t                 fifo_r [2];
  logic [1:0]           cnt_q_r, cnt_q_nxt;
  logic                 wp_r, rp_r;
  logic                 accept, push;

  assign busy   = div_act_r || (cnt_q_r == 2'd2);
  assign accept = start && !busy;
  // Restoring divide, one quotient bit per cycle.
  assign rem_sh = {rem_r[ADDR_BITS-2:0], quo_r[ADDR_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {{(ADDR_BITS+1-SCNT_W){1'b0}}, sets_r};
  assign push   = div_act_r && (cnt_r == 0);

  always_comb begin
    div_act_nxt = div_act_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      div_act_nxt = 1'b1;
      rem_nxt = '0;
      quo_nxt = in_address;
      cnt_nxt = ($clog2(ADDR_BITS+1))'(ADDR_BITS);
    end else if (div_act_r) begin
      if (cnt_r == 0) begin
        div_act_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (!diff[ADDR_BITS]) begin
          rem_nxt = diff[ADDR_BITS-1:0];
          quo_nxt = {quo_r[ADDR_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[ADDR_BITS-2:0], 1'b0};
        end
      end
    end
    cnt_q_nxt = cnt_q_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r <= 1'b0;
      cnt_q_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      div_act_r <= div_act_nxt;
      cnt_q_r <= cnt_q_nxt;
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (accept) begin
      put_r <= in_cmd;
      data_r <= in_data_in;
      sets_r <= sets;
      ways_r <= ways;
    end
    if (push) begin
      fifo_r[wp_r] <= '{is_put: put_r, set_idx: rem_r[SET_W-1:0], tag: quo_r,
                        data: data_r, ways: ways_r};
    end
  end

  assign q_valid = cnt_q_r != 2'd0;
  assign q_req   = fifo_r[rp_r];
endmodule

// ===== sv/salc_back.sv =====
// Back end: set lookup, LRU replacement and result generation.
module salc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  salc_pkg::req_t       q_req,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [31:0]          out_read_data,
  output logic [31:0]          out_hit_total,
  output logic [31:0]          out_miss_total
);
  import salc_pkg::*;

  logic [MAX_WAYS-1:0]  valid_r [MAX_SETS];
  logic [WAY_W-1:0]     rank_r  [MAX_SETS][MAX_WAYS];
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0][DATA_BITS-1:0] data_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_rd;
  logic [MAX_WAYS-1:0][DATA_BITS-1:0] data_rd;
  logic                 rd_r;
  req_t                 req_r;
  logic [CNT_W-1:0]     hits_r, miss_r;
  logic                 hit;
  logic [WAY_W-1:0]     hw, fw, vw, w;
  logic                 hfound, ffound;
  logic [WAY_W-1:0]     best, top, old;
  logic [MAX_WAYS-1:0]  in_use;

  assign q_pop = q_valid && !rd_r;

  always_ff @(posedge clk) begin
    tag_rd  <= tag_mem[q_req.set_idx];
    data_rd <= data_mem[q_req.set_idx];
    if (q_pop) req_r <= q_req;
  end

  always_comb begin
    top = WAY_W'(req_r.ways - 1'b1);
    for (int k = 0; k < MAX_WAYS; k++) in_use[k] = k < int'(req_r.ways);
    hfound = 1'b0; hw = '0; ffound = 1'b0; fw = '0; best = '0; vw = '0;
    for (int k = MAX_WAYS-1; k >= 0; k--) begin
      if (in_use[k] && valid_r[req_r.set_idx][k] && tag_rd[k] == req_r.tag) begin
        hfound = 1'b1; hw = WAY_W'(k);
      end
      if (in_use[k] && !valid_r[req_r.set_idx][k]) begin
        ffound = 1'b1; fw = WAY_W'(k);
      end
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && rank_r[req_r.set_idx][k] > best) begin
        best = rank_r[req_r.set_idx][k]; vw = WAY_W'(k);
      end
    end
    hit = hfound;
    w = hfound ? hw : (ffound ? fw : vw);
    old = hfound ? rank_r[req_r.set_idx][w] : top;
    if (old > top) old = top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      out_valid <= 1'b0;
      hits_r <= '0;
      miss_r <= '0;
      for (int s = 0; s < MAX_SETS; s++) begin
        valid_r[s] <= '0;
        for (int k = 0; k < MAX_WAYS; k++) rank_r[s][k] <= '0;
      end
    end else begin
      rd_r <= q_pop;
      out_valid <= rd_r;
      if (rd_r) begin
        for (int k = 0; k < MAX_WAYS; k++) begin
          if (WAY_W'(k) != w && in_use[k] && !(k == int'(w) ) &&
              (valid_r[req_r.set_idx][k] && !(!hit && !ffound && WAY_W'(k) == w)) &&
              rank_r[req_r.set_idx][k] < old && rank_r[req_r.set_idx][k] < top)
            rank_r[req_r.set_idx][k] <= rank_r[req_r.set_idx][k] + 1'b1;
        end
        rank_r[req_r.set_idx][w] <= '0;
        valid_r[req_r.set_idx][w] <= 1'b1;
        if (!req_r.is_put) begin
          if (hit) hits_r <= hits_r + 1'b1;
          else miss_r <= miss_r + 1'b1;
        end
      end
    end
    if (rd_r) begin
      tag_mem[req_r.set_idx][w] <= req_r.tag;
      if (req_r.is_put || !hit) data_mem[req_r.set_idx][w] <= req_r.data;
      out_hit <= hit;
      out_read_data <= req_r.is_put ? '0 : (hit ? data_rd[w] : req_r.data);
    end
  end

  assign out_hit_total  = hits_r;
  assign out_miss_total = miss_r;
endmodule

// ===== sv/set_assoc_lru_cache.sv =====
// Top level of the set-associative LRU cache.
// Usage:
//   Raise start with in_cmd (0 get, 1 put), in_address and in_data_in; the
//   access is taken at a clock edge where start is high and busy is low.
//   The front end divides the address by set_count with a restoring divider,
//   one quotient bit per cycle, and stays busy while dividing or while the
//   two-entry queue to the back end is full. The back end reads the set,
//   then updates it with a registered result, and takes no new access
//   while updating.
//   Each result shows on out_* for one cycle with out_valid high; the
//   receiver cannot stall it. out_hit_total and out_miss_total carry running
//   get counts after that access.
//   Configuration: cfg_we, cfg_index (0 set_count, 1 way_count), cfg_wdata
//   (way_count takes cfg_wdata[2:0] only); write only while idle. Zero acts
//   as one, large values saturate. Reset (rst_n low, synchronous) empties
//   the cache, clears LRU ranks and counters, and sets 16 sets and 4 ways.
module set_assoc_lru_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [15:0] in_address,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_read_data,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import salc_pkg::*;

  logic [SCNT_W-1:0] sets_r;
  logic [WCNT_W-1:0] ways_r;
  logic              q_valid, q_pop;
  req_t              q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sets_r <= SCNT_W'(MAX_SETS);
      ways_r <= WCNT_W'(MAX_WAYS);
    end else if (cfg_we) begin
      if (cfg_index == REG_SET_COUNT[0]) begin
        if (cfg_wdata == 5'd0) sets_r <= SCNT_W'(1);
        else if (int'(cfg_wdata) > MAX_SETS) sets_r <= SCNT_W'(MAX_SETS);
        else sets_r <= SCNT_W'(cfg_wdata);
      end else begin
        if (cfg_wdata[2:0] == 3'd0) ways_r <= WCNT_W'(1);
        else if (int'(cfg_wdata[2:0]) > MAX_WAYS) ways_r <= WCNT_W'(MAX_WAYS);
        else ways_r <= WCNT_W'(cfg_wdata[2:0]);
      end
    end
  end

  salc_front u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_address, .in_data_in,
    .sets(sets_r), .ways(ways_r), .q_valid, .q_req, .q_pop
  );

  salc_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop, .out_valid, .out_hit,
    .out_read_data, .out_hit_total, .out_miss_total
  );
endmodule

// ===== sv/salc_checker.sv =====
// Port-level checker for the set-associative LRU cache, bound to the top.
module salc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_hit_total,
  input logic [31:0] out_miss_total
);
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid) && !out_valid && $past(rst_n) |->
      $stable(out_hit_total) && $stable(out_miss_total))
    else $error("totals changed without a result");
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(out_valid) |->
      !(out_hit_total != $past(out_hit_total) && out_miss_total != $past(out_miss_total)))
    else $error("both totals moved");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front took access without going busy");
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results back to back");
endmodule

bind set_assoc_lru_cache salc_checker u_salc_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_hit_total, .out_miss_total
);
